// ===== hdl/matrix3x3_inverse_adjugate_macros.svh =====
// Assertion macros shared by the checker of the 3x3 matrix inverse.
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef MATRIX3X3_INVERSE_ADJUGATE_MACROS_SVH
`define MATRIX3X3_INVERSE_ADJUGATE_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at that edge too.
`define M3INV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never be true outside of reset.
`define M3INV_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== hdl/m3inv_pkg.sv =====
// Shared constants and index helpers for the 3x3 matrix inverse.
// No dependencies.
package m3inv_pkg;

	localparam int ELEMENT_BITS_DEF  = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// Row or column of the first and second remaining line of a 2x2 minor.
	function automatic int unsigned minor_lo(input int unsigned idx);
		return (idx == 0) ? 1 : 0;
	endfunction

	function automatic int unsigned minor_hi(input int unsigned idx);
		return (idx == 2) ? 1 : 2;
	endfunction

endpackage

// ===== hdl/matrix3x3_inverse_adjugate.sv =====
// Pipelined 3x3 matrix inverse by the adjugate method, fixed point.
// Depends on m3inv_pkg.
//
// One matrix is taken on every cycle that start is high; busy is always low because the
// pipeline never stalls and the receiver cannot hold results off. Each result appears for
// one cycle with done high. Five stages form the products, cofactors and determinant, one
// stage checks for quotient overflow, ELEMENT_BITS + 1 stages develop one quotient bit each
// in a restoring divider for every element, and one stage saturates and registers the
// outputs. A zero determinant gives all-zero elements with singular set.
module matrix3x3_inverse_adjugate #(
	parameter int ELEMENT_BITS  = m3inv_pkg::ELEMENT_BITS_DEF,
	parameter int FRACTION_BITS = m3inv_pkg::FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [ELEMENT_BITS-1:0] in_r1c1,
	input  logic signed [ELEMENT_BITS-1:0] in_r1c2,
	input  logic signed [ELEMENT_BITS-1:0] in_r1c3,
	input  logic signed [ELEMENT_BITS-1:0] in_r2c1,
	input  logic signed [ELEMENT_BITS-1:0] in_r2c2,
	input  logic signed [ELEMENT_BITS-1:0] in_r2c3,
	input  logic signed [ELEMENT_BITS-1:0] in_r3c1,
	input  logic signed [ELEMENT_BITS-1:0] in_r3c2,
	input  logic signed [ELEMENT_BITS-1:0] in_r3c3,
	output logic                           done,
	output logic signed [ELEMENT_BITS-1:0] out_r1c1,
	output logic signed [ELEMENT_BITS-1:0] out_r1c2,
	output logic signed [ELEMENT_BITS-1:0] out_r1c3,
	output logic signed [ELEMENT_BITS-1:0] out_r2c1,
	output logic signed [ELEMENT_BITS-1:0] out_r2c2,
	output logic signed [ELEMENT_BITS-1:0] out_r2c3,
	output logic signed [ELEMENT_BITS-1:0] out_r3c1,
	output logic signed [ELEMENT_BITS-1:0] out_r3c2,
	output logic signed [ELEMENT_BITS-1:0] out_r3c3,
	output logic                           singular,
	output logic                           overflow
);
	import m3inv_pkg::*;

	localparam int EW  = ELEMENT_BITS;
	localparam int PW  = 2 * EW;
	localparam int CW  = 2 * EW + 1;
	localparam int DW  = 3 * EW + 3;
	localparam int QB  = EW + 1;
	localparam int NA  = 2 * EW + 2 * FRACTION_BITS + 3;
	localparam int NW  = ((NA > DW) ? NA : DW) + 1;
	localparam int RB  = DW + 1 + QB;
	localparam int RW  = ((NW > RB) ? NW : RB) + 1;
	localparam int SH  = 2 * FRACTION_BITS + 1;

	logic signed [EW-1:0] a_in [9];

	assign a_in[0] = in_r1c1;
	assign a_in[1] = in_r1c2;
	assign a_in[2] = in_r1c3;
	assign a_in[3] = in_r2c1;
	assign a_in[4] = in_r2c2;
	assign a_in[5] = in_r2c3;
	assign a_in[6] = in_r3c1;
	assign a_in[7] = in_r3c2;
	assign a_in[8] = in_r3c3;

	assign busy = 1'b0;

	// Stage 1: the two products of every 2x2 minor.
	logic                 v_s1;
	logic signed [PW-1:0] pa_s1 [9];
	logic signed [PW-1:0] pb_s1 [9];
	logic signed [EW-1:0] a0_s1 [3];

	// Stage 2: cofactors.
	logic                 v_s2;
	logic signed [CW-1:0] cof_s2 [9];
	logic signed [EW-1:0] a0_s2 [3];

	// Stage 3: split partial products of the first-row expansion.
	logic                  v_s3;
	logic signed [CW-1:0]  cof_s3 [9];
	logic signed [PW:0]    dhi_s3 [3];
	logic signed [PW:0]    dlo_s3 [3];

	// Stage 4: determinant.
	logic                 v_s4;
	logic signed [CW-1:0] cof_s4 [9];
	logic signed [DW-1:0] det_s4;

	// Stage 5: magnitudes and scaled numerators.
	logic          v_s5;
	logic          sing_s5;
	logic [DW-1:0] dmag_s5;
	logic [NW-1:0] num_s5 [9];
	logic [8:0]    neg_s5;

	logic signed [CW-1:0] cof_nx [9];
	logic signed [DW-1:0] det_nx;
	logic [DW-1:0]        dmag_nx;
	logic [NW-1:0]        num_nx [9];
	logic [8:0]           neg_nx;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				cof_nx[r*3+c] = CW'(pa_s1[r*3+c]) - CW'(pb_s1[r*3+c]);
				if (((r + c) % 2) == 1) begin
					cof_nx[r*3+c] = -cof_nx[r*3+c];
				end
			end
		end
	end

	always_comb begin
		det_nx = '0;
		for (int c = 0; c < 3; c++) begin
			det_nx = det_nx + (DW'(dhi_s3[c]) <<< EW) + DW'(dlo_s3[c]);
		end
	end

	always_comb begin
		logic [CW-1:0] cmag;
		dmag_nx = det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				// The inverse is the transposed cofactor matrix over the determinant.
				cmag = cof_s4[c*3+r][CW-1] ? CW'(-cof_s4[c*3+r]) : CW'(cof_s4[c*3+r]);
				neg_nx[r*3+c] = cof_s4[c*3+r][CW-1] ^ det_s4[DW-1];
				num_nx[r*3+c] = (NW'(cmag) << SH) + NW'(dmag_nx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				pa_s1[r*3+c] <= a_in[minor_lo(r)*3 + minor_lo(c)]
					* a_in[minor_hi(r)*3 + minor_hi(c)];
				pb_s1[r*3+c] <= a_in[minor_lo(r)*3 + minor_hi(c)]
					* a_in[minor_hi(r)*3 + minor_lo(c)];
			end
		end
		for (int c = 0; c < 3; c++) begin
			a0_s1[c]  <= a_in[c];
			a0_s2[c]  <= a0_s1[c];
			dhi_s3[c] <= a0_s2[c] * $signed(cof_s2[c][CW-1:EW]);
			dlo_s3[c] <= a0_s2[c] * $signed({1'b0, cof_s2[c][EW-1:0]});
		end
		for (int k = 0; k < 9; k++) begin
			cof_s2[k] <= cof_nx[k];
			cof_s3[k] <= cof_s2[k];
			cof_s4[k] <= cof_s3[k];
			num_s5[k] <= num_nx[k];
		end
		det_s4  <= det_nx;
		sing_s5 <= (det_s4 == '0);
		dmag_s5 <= dmag_nx;
		neg_s5  <= neg_nx;
	end

	// Divider: entry check for a quotient too large to develop, then one bit per stage.
	logic          dv_v_s    [QB+1];
	logic [RW-1:0] dv_rem_s  [QB+1][9];
	logic [QB-1:0] dv_q_s    [QB+1][9];
	logic [DW-1:0] dv_dmag_s [QB+1];
	logic [8:0]    dv_big_s  [QB+1];
	logic [8:0]    dv_neg_s  [QB+1];
	logic          dv_sing_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			dv_rem_s[0][k] <= RW'(num_s5[k]);
			dv_q_s[0][k]   <= '0;
			dv_big_s[0][k] <= (RW'(num_s5[k]) >= (RW'(dmag_s5) << (QB + 1)));
		end
		dv_dmag_s[0] <= dmag_s5;
		dv_neg_s[0]  <= neg_s5;
		dv_sing_s[0] <= sing_s5;
	end

	for (genvar t = 0; t < QB; t++) begin : g_div
		localparam int BI = QB - 1 - t;

		logic [RW-1:0] dsh;
		logic [RW-1:0] rem_nx [9];
		logic [QB-1:0] q_nx   [9];

		assign dsh = RW'(dv_dmag_s[t]) << (BI + 1);

		always_comb begin
			for (int k = 0; k < 9; k++) begin
				rem_nx[k] = dv_rem_s[t][k];
				q_nx[k]   = dv_q_s[t][k];
				if (dv_rem_s[t][k] >= dsh) begin
					rem_nx[k]   = dv_rem_s[t][k] - dsh;
					q_nx[k][BI] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[t+1] <= 1'b0;
			end else begin
				dv_v_s[t+1] <= dv_v_s[t];
			end
		end

		always_ff @(posedge clk) begin
			for (int k = 0; k < 9; k++) begin
				dv_rem_s[t+1][k] <= rem_nx[k];
				dv_q_s[t+1][k]   <= q_nx[k];
			end
			dv_dmag_s[t+1] <= dv_dmag_s[t];
			dv_big_s[t+1]  <= dv_big_s[t];
			dv_neg_s[t+1]  <= dv_neg_s[t];
			dv_sing_s[t+1] <= dv_sing_s[t];
		end
	end

	// Output stage: saturation to the element range.
	localparam logic [QB-1:0] LIM_POS = {2'b00, {(EW-1){1'b1}}};
	localparam logic [QB-1:0] LIM_NEG = {2'b01, {(EW-1){1'b0}}};

	logic [EW-1:0] res_nx [9];
	logic          ovf_nx;
	logic          done_q;
	logic [EW-1:0] res_q  [9];
	logic          sing_q;
	logic          ovf_q;

	always_comb begin
		logic [QB-1:0] q;
		ovf_nx = 1'b0;
		for (int k = 0; k < 9; k++) begin
			q = dv_q_s[QB][k];
			if (dv_neg_s[QB][k]) begin
				if (dv_big_s[QB][k] || (q > LIM_NEG)) begin
					res_nx[k] = LIM_NEG[EW-1:0];
					ovf_nx    = 1'b1;
				end else begin
					res_nx[k] = EW'(-q);
				end
			end else begin
				if (dv_big_s[QB][k] || (q > LIM_POS)) begin
					res_nx[k] = LIM_POS[EW-1:0];
					ovf_nx    = 1'b1;
				end else begin
					res_nx[k] = q[EW-1:0];
				end
			end
			if (dv_sing_s[QB]) begin
				res_nx[k] = '0;
			end
		end
		if (dv_sing_s[QB]) begin
			ovf_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			res_q[k] <= res_nx[k];
		end
		sing_q <= dv_sing_s[QB];
		ovf_q  <= ovf_nx;
	end

	assign done     = done_q;
	assign out_r1c1 = res_q[0];
	assign out_r1c2 = res_q[1];
	assign out_r1c3 = res_q[2];
	assign out_r2c1 = res_q[3];
	assign out_r2c2 = res_q[4];
	assign out_r2c3 = res_q[5];
	assign out_r3c1 = res_q[6];
	assign out_r3c2 = res_q[7];
	assign out_r3c3 = res_q[8];
	assign singular = sing_q;
	assign overflow = ovf_q;

endmodule

// ===== hdl/m3inv_chk.sv =====
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
// Depends on m3inv_pkg and matrix3x3_inverse_adjugate_macros.svh.
`include "matrix3x3_inverse_adjugate_macros.svh"

module m3inv_chk #(
	parameter int ELEMENT_BITS = m3inv_pkg::ELEMENT_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [ELEMENT_BITS-1:0] out_r1c1,
	input logic [ELEMENT_BITS-1:0] out_r2c2,
	input logic [ELEMENT_BITS-1:0] out_r3c3,
	input logic                    singular,
	input logic                    overflow
);
	import m3inv_pkg::*;

	localparam int LATENCY = ELEMENT_BITS + 8;

	`M3INV_ASSERT_NEVER(a_never_busy, busy, "busy raised although the pipeline never stalls")

	// Every result beat goes back to an earlier start beat.
	`M3INV_ASSERT_IMPL(a_latency, done, $past(start, LATENCY), "result beat without a start beat")

	`M3INV_ASSERT_IMPL(a_sing_zero, done && singular,
		!overflow && out_r1c1 == '0 && out_r2c2 == '0 && out_r3c3 == '0,
		"singular result with nonzero elements or overflow")

	`M3INV_ASSERT_IMPL(a_start_done, $past(start && !busy, LATENCY), done,
		"result beat missing after a start beat")

endmodule

bind matrix3x3_inverse_adjugate m3inv_chk #(.ELEMENT_BITS(ELEMENT_BITS)) u_m3inv_chk (.*);

// ===== tb/matrix3x3_inverse_adjugate_test.sv =====
// Self-checking testbench for the pipelined 3x3 matrix inverse (adjugate method, Q16.16).
// Depends on m3inv_pkg and matrix3x3_inverse_adjugate; exact wide-integer inverse predicted here.
`timescale 1ns / 1ps

module matrix3x3_inverse_adjugate_test;

	localparam int EW = m3inv_pkg::ELEMENT_BITS_DEF;
	localparam int FW = m3inv_pkg::FRACTION_BITS_DEF;
	localparam int SETTLE_CYCLES = EW + 20;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 450;
	localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};
	localparam logic signed [EW-1:0] ONE = 1 <<< FW;

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [159:0] wide_t;
	typedef struct {
		elem_t e[9];
	} matrix_t;
	typedef struct {
		elem_t e[9];
		logic  singular;
		logic  overflow;
	} inverse_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	elem_t mat_in[9];
	logic  busy, done, singular, overflow;
	elem_t inv_out[9];

	matrix_t  pending_matrices[$];
	inverse_t expected_inverses[$];
	bit       failed = 1'b0;
	bit       took_beat = 1'b0;
	int       matrices_sent = 0;
	int       idle_pct = 0;
	int       quiet_cycles = 0;

	initial for (int k = 0; k < 9; k++) mat_in[k] = '0;

	matrix3x3_inverse_adjugate dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_r1c1(mat_in[0]), .in_r1c2(mat_in[1]), .in_r1c3(mat_in[2]),
		.in_r2c1(mat_in[3]), .in_r2c2(mat_in[4]), .in_r2c3(mat_in[5]),
		.in_r3c1(mat_in[6]), .in_r3c2(mat_in[7]), .in_r3c3(mat_in[8]),
		.done(done),
		.out_r1c1(inv_out[0]), .out_r1c2(inv_out[1]), .out_r1c3(inv_out[2]),
		.out_r2c1(inv_out[3]), .out_r2c2(inv_out[4]), .out_r2c3(inv_out[5]),
		.out_r3c1(inv_out[6]), .out_r3c2(inv_out[7]), .out_r3c3(inv_out[8]),
		.singular(singular), .overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact inverse: cofactors and determinant held at full width, each quotient rounded
	// half away from zero, then saturated to the element range.
	function automatic inverse_t predict_inverse(matrix_t m);
		wide_t    a[3][3];
		wide_t    cof[3][3];
		wide_t    det, dmag, num, q, mnr;
		wide_t    pos_lim, neg_lim;
		bit       neg;
		int       r1, r2, c1, c2;
		inverse_t res;
		pos_lim = EMAX;
		neg_lim = pos_lim + 1;
		for (int k = 0; k < 9; k++) a[k / 3][k % 3] = m.e[k];
		for (int r = 0; r < 3; r++) begin
			r1 = (r == 0) ? 1 : 0;
			r2 = (r == 2) ? 1 : 2;
			for (int c = 0; c < 3; c++) begin
				c1 = (c == 0) ? 1 : 0;
				c2 = (c == 2) ? 1 : 2;
				mnr = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
				cof[r][c] = ((r + c) % 2 == 1) ? -mnr : mnr;
			end
		end
		det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
		res.singular = (det == 0);
		res.overflow = 1'b0;
		if (det == 0) begin
			for (int k = 0; k < 9; k++) res.e[k] = '0;
			return res;
		end
		dmag = (det < 0) ? -det : det;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				num = cof[c][r];
				neg = (num < 0) != (det < 0);
				if (num < 0) num = -num;
				q = ((num <<< (2 * FW + 1)) + dmag) / (dmag <<< 1);
				if (neg) begin
					if (q > neg_lim) begin
						q = neg_lim;
						res.overflow = 1'b1;
					end
					q = -q;
				end else if (q > pos_lim) begin
					q = pos_lim;
					res.overflow = 1'b1;
				end
				res.e[3 * r + c] = q[EW-1:0];
			end
		end
		return res;
	endfunction

	function automatic matrix_t diag_matrix(elem_t d0, elem_t d1, elem_t d2);
		matrix_t m;
		for (int k = 0; k < 9; k++) m.e[k] = '0;
		m.e[0] = d0;
		m.e[4] = d1;
		m.e[8] = d2;
		return m;
	endfunction

	function automatic elem_t modest_elem();
		return $signed($urandom_range(2 * (ONE * 4))) - ONE * 4;
	endfunction

	function automatic matrix_t random_matrix();
		matrix_t m;
		int      kind;
		int      src, dst;
		kind = $urandom_range(9);
		for (int k = 0; k < 9; k++)
			m.e[k] = (kind < 3) ? elem_t'($urandom) : modest_elem();
		if (kind == 3 || kind == 4) begin
			// Copy one row over another, optionally negated, to make it singular.
			src = $urandom_range(2);
			dst = (src + 1 + $urandom_range(1)) % 3;
			for (int c = 0; c < 3; c++)
				m.e[3 * dst + c] = (kind == 4) ? -m.e[3 * src + c] : m.e[3 * src + c];
		end else if (kind == 5) begin
			// Tiny elements push the inverse into saturation.
			for (int k = 0; k < 9; k++) m.e[k] = $signed($urandom_range(64)) - 32;
		end else if (kind == 6) begin
			for (int k = 0; k < 9; k++)
				m.e[k] = ($urandom_range(1) == 1) ? EMAX : EMIN;
		end
		return m;
	endfunction

	task automatic m_drive(matrix_t m);
		start <= 1'b1;
		for (int k = 0; k < 9; k++) mat_in[k] <= m.e[k];
	endtask

	initial begin
		matrix_t m;
		m = diag_matrix(ONE, ONE, ONE);                pending_matrices.push_back(m);
		m = diag_matrix(-ONE, -ONE, -ONE);             pending_matrices.push_back(m);
		m = diag_matrix(0, 0, 0);                      pending_matrices.push_back(m);
		m = diag_matrix(EMAX, EMAX, EMAX);             pending_matrices.push_back(m);
		m = diag_matrix(EMIN, EMIN, EMIN);             pending_matrices.push_back(m);
		m = diag_matrix(EMIN, EMAX, EMIN);             pending_matrices.push_back(m);
		m = diag_matrix(1, 1, 1);                      pending_matrices.push_back(m);
		m = diag_matrix(-1, 1, 1);                     pending_matrices.push_back(m);
		m = diag_matrix(2 * ONE, ONE / 2, -4 * ONE);   pending_matrices.push_back(m);
		m = diag_matrix(3 * ONE, 3 * ONE, 3 * ONE);    pending_matrices.push_back(m);
		m = diag_matrix(ONE, ONE, 0);                  pending_matrices.push_back(m);
		for (int k = 0; k < 9; k++) m.e[k] = EMAX;
		pending_matrices.push_back(m);
		for (int k = 0; k < 9; k++) m.e[k] = EMIN;
		pending_matrices.push_back(m);
		for (int k = 0; k < 9; k++) m.e[k] = (k + 1) * ONE;
		pending_matrices.push_back(m);
		for (int k = 0; k < 9; k++) m.e[k] = (k % 2 == 0) ? EMAX : EMIN;
		pending_matrices.push_back(m);
		for (int k = 0; k < 9; k++) m.e[k] = '1;
		m.e[0] = EMIN;
		pending_matrices.push_back(m);
		m = diag_matrix(ONE, ONE, ONE);
		m.e[1] = EMAX;
		m.e[5] = EMIN;
		pending_matrices.push_back(m);
		for (int n = 0; n < RANDOM_ITEMS; n++) pending_matrices.push_back(random_matrix());

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (pending_matrices.size() == 0 && !start && expected_inverses.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (!failed)
			$display("matrix3x3_inverse_adjugate_test: PASS");
		else
			$display("matrix3x3_inverse_adjugate_test: FAIL");
		$finish;
	end

	// Idling phases follow the count of matrices sent.
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !took_beat) begin
				// Beat not taken yet: hold it.
			end else begin
				if (matrices_sent < 140) idle_pct = 0;
				else if (matrices_sent < 260) idle_pct = 62;
				else if (matrices_sent < 370) idle_pct = 22;
				else idle_pct = 0;
				if (pending_matrices.size() == 0 ||
				    (matrices_sent == 200 && expected_inverses.size() != 0) ||
				    $urandom_range(99) < idle_pct) begin
					start <= 1'b0;
				end else begin
					m_drive(pending_matrices.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		matrix_t  cur;
		inverse_t want;
		took_beat = arst_n && start && !busy;
		quiet_cycles = quiet_cycles + 1;
		if (took_beat) begin
			for (int k = 0; k < 9; k++) cur.e[k] = mat_in[k];
			expected_inverses.push_back(predict_inverse(cur));
			matrices_sent = matrices_sent + 1;
			quiet_cycles = 0;
		end
		if (arst_n && done) begin
			quiet_cycles = 0;
			if (expected_inverses.size() == 0) begin
				$display("%0t: result beat with no matrix outstanding", $time);
				failed = 1'b1;
			end else begin
				want = expected_inverses.pop_front();
				for (int k = 0; k < 9; k++)
					if (inv_out[k] !== want.e[k]) begin
						$display("%0t: out_r%0dc%0d expected %h got %h", $time,
							k / 3 + 1, k % 3 + 1, want.e[k], inv_out[k]);
						failed = 1'b1;
					end
				if (singular !== want.singular) begin
					$display("%0t: singular expected %b got %b", $time,
						want.singular, singular);
					failed = 1'b1;
				end
				if (overflow !== want.overflow) begin
					$display("%0t: overflow expected %b got %b", $time,
						want.overflow, overflow);
					failed = 1'b1;
				end
			end
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("matrix3x3_inverse_adjugate_test: FAIL");
			$finish;
		end
	end

endmodule
